// ===== hw/rtl/gwtc_pkg.sv =====
package gwtc_pkg;

    // Field widths
    localparam int WEEK_W   = 13;
    localparam int TOW_W    = 30;
    localparam int YEAR_W   = 12;
    localparam int DOY_W    = 9;
    localparam int MONTH_W  = 4;
    localparam int DOM_W    = 5;
    localparam int HOUR_W   = 5;
    localparam int MINUTE_W = 6;
    localparam int SECMS_W  = 16;

    // Internal widths
    localparam int WDAYS_W  = 4;   // whole days in a time of week, 0..12
    localparam int DAYS_W   = 17;  // day count since 1 Jan 1901
    localparam int MSDAY_W  = 27;  // milliseconds within a day
    localparam int MSHOUR_W = 22;  // milliseconds within an hour
    localparam int CYCLE_W  = 6;   // four-year cycles since 1901
    localparam int LEFT_W   = 11;  // day within a four-year cycle

    // Time constants
    localparam int unsigned MS_PER_DAY    = 86400000;
    localparam int unsigned MS_PER_HOUR   = 3600000;
    localparam int unsigned MS_PER_MINUTE = 60000;
    localparam int          MAX_WHOLE_DAYS = 12;
    localparam int          HOURS_PER_DAY  = 24;

    // Calendar constants
    localparam int unsigned DAYS_TO_GPS_EPOCH = 28859;
    localparam int unsigned DAYS_PER_CYCLE    = 1461;
    localparam int unsigned DAYS_PER_YEAR     = 365;
    localparam int unsigned FIRST_CYCLE_YEAR  = 1901;
    localparam int          MONTHS            = 12;

    // Reciprocal for days / 1461, exact for any 17-bit day count
    localparam int          CYCLE_RECIP_W = 19;
    localparam int unsigned CYCLE_RECIP   = 367469;
    localparam int          CYCLE_SHIFT   = 29;
    localparam int          CYCLE_PROD_W  = DAYS_W + CYCLE_RECIP_W;

    // Reciprocal for (ms >> 5) / 1875, exact for any 17-bit quotient
    localparam int          MIN_PRESHIFT = 5;
    localparam int          MIN_RECIP_W  = 18;
    localparam int unsigned MIN_RECIP    = 143166;
    localparam int          MIN_SHIFT    = 28;
    localparam int          MIN_PROD_W   = (MSHOUR_W - MIN_PRESHIFT) + MIN_RECIP_W;

    // Cumulative days before each month
    localparam logic [DOY_W-1:0] CUM_NORMAL [13] = '{
        9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
        9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365
    };
    localparam logic [DOY_W-1:0] CUM_LEAP [13] = '{
        9'd0, 9'd31, 9'd60, 9'd91, 9'd121, 9'd152, 9'd182,
        9'd213, 9'd244, 9'd274, 9'd305, 9'd335, 9'd366
    };

    typedef struct packed {
        logic [DAYS_W-1:0]  days;
        logic [MSDAY_W-1:0] ms_of_day;
    } front_t;

    typedef struct packed {
        logic [CYCLE_W-1:0]  cycles;
        logic [LEFT_W-1:0]   left;
        logic [HOUR_W-1:0]   hour;
        logic [MSHOUR_W-1:0] ms_of_hour;
    } mid_t;

    typedef struct packed {
        logic [YEAR_W-1:0]   year;
        logic [DOY_W-1:0]    day_of_year;
        logic [MONTH_W-1:0]  month;
        logic [DOM_W-1:0]    day_of_month;
        logic [HOUR_W-1:0]   hour;
        logic [MINUTE_W-1:0] minute;
        logic [SECMS_W-1:0]  second_ms;
    } result_t;

    // Days before month index idx (0 = before January)
    function automatic logic [DOY_W-1:0] cum_days(input logic leap,
                                                  input logic [MONTH_W-1:0] idx);
        logic [DOY_W-1:0] val;
        if (idx > MONTH_W'(MONTHS))
            val = '0;
        else if (leap)
            val = CUM_LEAP[idx];
        else
            val = CUM_NORMAL[idx];
        return val;
    endfunction

endpackage

// ===== hw/rtl/gwtc_if.sv =====
interface gwtc_in_if;
    logic                          valid;
    logic                          ready;
    logic [gwtc_pkg::WEEK_W-1:0]   week_number;
    logic [gwtc_pkg::TOW_W-1:0]    tow_ms;

    modport source (output valid, output week_number, output tow_ms, input ready);
    modport sink   (input valid, input week_number, input tow_ms, output ready);
endinterface

interface gwtc_out_if;
    logic                            valid;
    logic                            ready;
    logic [gwtc_pkg::YEAR_W-1:0]     year;
    logic [gwtc_pkg::DOY_W-1:0]      day_of_year;
    logic [gwtc_pkg::MONTH_W-1:0]    month;
    logic [gwtc_pkg::DOM_W-1:0]      day_of_month;
    logic [gwtc_pkg::HOUR_W-1:0]     hour;
    logic [gwtc_pkg::MINUTE_W-1:0]   minute;
    logic [gwtc_pkg::SECMS_W-1:0]    second_ms;

    modport source (output valid, output year, output day_of_year, output month,
                    output day_of_month, output hour, output minute,
                    output second_ms, input ready);
    modport sink   (input valid, input year, input day_of_year, input month,
                    input day_of_month, input hour, input minute,
                    input second_ms, output ready);
endinterface

// ===== hw/rtl/gps_week_tow_to_calendar_top.sv =====
// GPS week and time of week to calendar date and time of day. Each transfer on
// in_ch carries a week number and a time of week in milliseconds; one transfer
// on out_ch returns year, day of year, month, day of month, hour, minute and
// milliseconds within the minute. The path is seven register stages deep, and a
// new input is taken every cycle while out_ch is not stalled; the two reciprocal
// multipliers (days by 1461, milliseconds by 60000) and the month lookup each
// have a stage of their own. Every stage has its own valid bit, so empty stages
// fill while out_ch is stalled. Dates are exact from 1980 through 2099; whole
// days of a time of week beyond one week carry into the date.
module gps_week_tow_to_calendar_top (
    input  logic        clk,
    input  logic        rst_n,
    gwtc_in_if.sink     in_ch,
    gwtc_out_if.source  out_ch
);

    logic               front_valid;
    logic               front_ready;
    gwtc_pkg::front_t   front_data;
    logic               mid_valid;
    logic               mid_ready;
    gwtc_pkg::mid_t     mid_data;
    gwtc_pkg::result_t  res_data;

    gwtc_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .up_valid    (in_ch.valid),
        .up_ready    (in_ch.ready),
        .week_number (in_ch.week_number),
        .tow_ms      (in_ch.tow_ms),
        .dn_valid    (front_valid),
        .dn_ready    (front_ready),
        .dn_data     (front_data)
    );

    gwtc_mid u_mid (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (front_valid),
        .up_ready (front_ready),
        .up_data  (front_data),
        .dn_valid (mid_valid),
        .dn_ready (mid_ready),
        .dn_data  (mid_data)
    );

    gwtc_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (mid_valid),
        .up_ready (mid_ready),
        .up_data  (mid_data),
        .dn_valid (out_ch.valid),
        .dn_ready (out_ch.ready),
        .dn_data  (res_data)
    );

    // Drive result fields
    assign out_ch.year         = res_data.year;
    assign out_ch.day_of_year  = res_data.day_of_year;
    assign out_ch.month        = res_data.month;
    assign out_ch.day_of_month = res_data.day_of_month;
    assign out_ch.hour         = res_data.hour;
    assign out_ch.minute       = res_data.minute;
    assign out_ch.second_ms    = res_data.second_ms;

endmodule

// ===== hw/rtl/gwtc_front.sv =====
module gwtc_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          up_valid,
    output logic                          up_ready,
    input  logic [gwtc_pkg::WEEK_W-1:0]   week_number,
    input  logic [gwtc_pkg::TOW_W-1:0]    tow_ms,
    output logic                          dn_valid,
    input  logic                          dn_ready,
    output gwtc_pkg::front_t              dn_data
);

    logic                             s1_valid_reg;
    logic [gwtc_pkg::WEEK_W-1:0]      s1_week_reg;
    logic [gwtc_pkg::TOW_W-1:0]       s1_tow_reg;
    logic [gwtc_pkg::WDAYS_W-1:0]     s1_wdays_reg;
    logic [gwtc_pkg::WDAYS_W-1:0]     s1_wdays_next;
    logic                             s2_valid_reg;
    gwtc_pkg::front_t                 s2_data_reg;
    gwtc_pkg::front_t                 s2_data_next;
    logic                             s1_ready;
    logic                             s2_ready;

    // Stage handshake: a stage takes new data when empty or draining
    assign s2_ready = !s2_valid_reg || dn_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign up_ready = s1_ready;

    // Count whole days in the time of week
    always_comb
    begin
        s1_wdays_next = '0;
        for (int k = 1; k <= gwtc_pkg::MAX_WHOLE_DAYS; k++)
        begin
            if (tow_ms >= gwtc_pkg::TOW_W'(k * gwtc_pkg::MS_PER_DAY))
                s1_wdays_next = s1_wdays_next + 1'b1;
        end
    end

    // Remove whole days, form the day count since 1901
    always_comb
    begin
        s2_data_next.ms_of_day = gwtc_pkg::MSDAY_W'(s1_tow_reg
            - gwtc_pkg::TOW_W'(s1_wdays_reg) * gwtc_pkg::TOW_W'(gwtc_pkg::MS_PER_DAY));
        s2_data_next.days = gwtc_pkg::DAYS_W'(s1_week_reg) * gwtc_pkg::DAYS_W'(7)
            + gwtc_pkg::DAYS_W'(s1_wdays_reg)
            + gwtc_pkg::DAYS_W'(gwtc_pkg::DAYS_TO_GPS_EPOCH);
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
                s1_valid_reg <= up_valid;
            if (s2_ready)
                s2_valid_reg <= s1_valid_reg;
        end
    end

    // Load payload on transfer into each stage
    always_ff @(posedge clk)
    begin
        if (s1_ready && up_valid)
        begin
            s1_week_reg  <= week_number;
            s1_tow_reg   <= tow_ms;
            s1_wdays_reg <= s1_wdays_next;
        end
        if (s2_ready && s1_valid_reg)
            s2_data_reg <= s2_data_next;
    end

    assign dn_valid = s2_valid_reg;
    assign dn_data  = s2_data_reg;

    a_ms_of_day_range: assert property (@(posedge clk) disable iff (!rst_n)
        dn_valid |-> dn_data.ms_of_day < gwtc_pkg::MSDAY_W'(gwtc_pkg::MS_PER_DAY))
        else $error("millisecond of day out of range");

endmodule

// ===== hw/rtl/gwtc_mid.sv =====
module gwtc_mid (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              up_valid,
    output logic              up_ready,
    input  gwtc_pkg::front_t  up_data,
    output logic              dn_valid,
    input  logic              dn_ready,
    output gwtc_pkg::mid_t    dn_data
);

    logic                               s3_valid_reg;
    logic [gwtc_pkg::DAYS_W-1:0]        s3_days_reg;
    logic [gwtc_pkg::MSDAY_W-1:0]       s3_ms_reg;
    logic [gwtc_pkg::CYCLE_W-1:0]       s3_cycles_reg;
    logic [gwtc_pkg::CYCLE_W-1:0]       s3_cycles_next;
    logic [gwtc_pkg::HOUR_W-1:0]        s3_hour_reg;
    logic [gwtc_pkg::HOUR_W-1:0]        s3_hour_next;
    logic [gwtc_pkg::CYCLE_PROD_W-1:0]  cycle_prod;
    logic                               s4_valid_reg;
    gwtc_pkg::mid_t                     s4_data_reg;
    gwtc_pkg::mid_t                     s4_data_next;
    logic                               s3_ready;
    logic                               s4_ready;

    assign s4_ready = !s4_valid_reg || dn_ready;
    assign s3_ready = !s3_valid_reg || s4_ready;
    assign up_ready = s3_ready;

    // Divide day count by 1461 through its reciprocal
    assign cycle_prod = gwtc_pkg::CYCLE_PROD_W'(up_data.days)
        * gwtc_pkg::CYCLE_PROD_W'(gwtc_pkg::CYCLE_RECIP);
    assign s3_cycles_next = gwtc_pkg::CYCLE_W'(cycle_prod >> gwtc_pkg::CYCLE_SHIFT);

    // Count whole hours in the day
    always_comb
    begin
        s3_hour_next = '0;
        for (int k = 1; k < gwtc_pkg::HOURS_PER_DAY; k++)
        begin
            if (up_data.ms_of_day >= gwtc_pkg::MSDAY_W'(k * gwtc_pkg::MS_PER_HOUR))
                s3_hour_next = s3_hour_next + 1'b1;
        end
    end

    // Take remainders of day in cycle and millisecond in hour
    always_comb
    begin
        s4_data_next.cycles = s3_cycles_reg;
        s4_data_next.hour   = s3_hour_reg;
        s4_data_next.left   = gwtc_pkg::LEFT_W'(s3_days_reg
            - gwtc_pkg::DAYS_W'(s3_cycles_reg)
            * gwtc_pkg::DAYS_W'(gwtc_pkg::DAYS_PER_CYCLE));
        s4_data_next.ms_of_hour = gwtc_pkg::MSHOUR_W'(s3_ms_reg
            - gwtc_pkg::MSDAY_W'(s3_hour_reg)
            * gwtc_pkg::MSDAY_W'(gwtc_pkg::MS_PER_HOUR));
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            if (s3_ready)
                s3_valid_reg <= up_valid;
            if (s4_ready)
                s4_valid_reg <= s3_valid_reg;
        end
    end

    // Load payload on transfer into each stage
    always_ff @(posedge clk)
    begin
        if (s3_ready && up_valid)
        begin
            s3_days_reg   <= up_data.days;
            s3_ms_reg     <= up_data.ms_of_day;
            s3_cycles_reg <= s3_cycles_next;
            s3_hour_reg   <= s3_hour_next;
        end
        if (s4_ready && s3_valid_reg)
            s4_data_reg <= s4_data_next;
    end

    assign dn_valid = s4_valid_reg;
    assign dn_data  = s4_data_reg;

    a_left_range: assert property (@(posedge clk) disable iff (!rst_n)
        dn_valid |-> dn_data.left < gwtc_pkg::LEFT_W'(gwtc_pkg::DAYS_PER_CYCLE))
        else $error("day within cycle out of range");

    a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
        dn_valid |-> (dn_data.hour < gwtc_pkg::HOUR_W'(gwtc_pkg::HOURS_PER_DAY))
            && (dn_data.ms_of_hour < gwtc_pkg::MSHOUR_W'(gwtc_pkg::MS_PER_HOUR)))
        else $error("hour split out of range");

endmodule

// ===== hw/rtl/gwtc_back.sv =====
module gwtc_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               up_valid,
    output logic               up_ready,
    input  gwtc_pkg::mid_t     up_data,
    output logic               dn_valid,
    input  logic               dn_ready,
    output gwtc_pkg::result_t  dn_data
);

    // Stage 5: year split and minute quotient
    logic                               s5_valid_reg;
    logic [gwtc_pkg::YEAR_W-1:0]        s5_year_reg;
    logic [gwtc_pkg::YEAR_W-1:0]        s5_year_next;
    logic [gwtc_pkg::DOY_W-1:0]         s5_doy_reg;
    logic [gwtc_pkg::DOY_W-1:0]         s5_doy_next;
    logic                               s5_leap_reg;
    logic [gwtc_pkg::HOUR_W-1:0]        s5_hour_reg;
    logic [gwtc_pkg::MSHOUR_W-1:0]      s5_ms_reg;
    logic [gwtc_pkg::MINUTE_W-1:0]      s5_minute_reg;
    logic [gwtc_pkg::MINUTE_W-1:0]      s5_minute_next;
    logic [1:0]                         extra;
    logic [1:0]                         year_steps;
    logic [gwtc_pkg::MIN_PROD_W-1:0]    min_prod;

    // Stage 6: month and millisecond in minute
    logic                               s6_valid_reg;
    gwtc_pkg::result_t                  s6_data_reg;
    gwtc_pkg::result_t                  s6_data_next;
    logic                               s6_leap_reg;
    logic [gwtc_pkg::MONTH_W-1:0]       guess;
    logic [gwtc_pkg::DOY_W-1:0]         guess_cum;
    logic [gwtc_pkg::LEFT_W-1:0]        doy_x4;

    // Stage 7: day of month
    logic                               s7_valid_reg;
    gwtc_pkg::result_t                  s7_data_reg;
    gwtc_pkg::result_t                  s7_data_next;

    logic                               s5_ready;
    logic                               s6_ready;
    logic                               s7_ready;

    assign s7_ready = !s7_valid_reg || dn_ready;
    assign s6_ready = !s6_valid_reg || s7_ready;
    assign s5_ready = !s5_valid_reg || s6_ready;
    assign up_ready = s5_ready;

    // Split the cycle day into year and day of year; the last day of the
    // cycle stays in the leap year
    always_comb
    begin
        year_steps = '0;
        if (up_data.left >= gwtc_pkg::LEFT_W'(gwtc_pkg::DAYS_PER_YEAR))
            year_steps = year_steps + 1'b1;
        if (up_data.left >= gwtc_pkg::LEFT_W'(2 * gwtc_pkg::DAYS_PER_YEAR))
            year_steps = year_steps + 1'b1;
        if (up_data.left >= gwtc_pkg::LEFT_W'(3 * gwtc_pkg::DAYS_PER_YEAR))
            year_steps = year_steps + 1'b1;
        extra = year_steps;
        s5_year_next = gwtc_pkg::YEAR_W'(gwtc_pkg::FIRST_CYCLE_YEAR)
            + (gwtc_pkg::YEAR_W'(up_data.cycles) << 2)
            + gwtc_pkg::YEAR_W'(extra);
        s5_doy_next = gwtc_pkg::DOY_W'(up_data.left
            - gwtc_pkg::LEFT_W'(extra) * gwtc_pkg::LEFT_W'(gwtc_pkg::DAYS_PER_YEAR)
            + gwtc_pkg::LEFT_W'(1));
    end

    // Divide millisecond in hour by 60000 through a reciprocal
    assign min_prod = gwtc_pkg::MIN_PROD_W'(up_data.ms_of_hour >> gwtc_pkg::MIN_PRESHIFT)
        * gwtc_pkg::MIN_PROD_W'(gwtc_pkg::MIN_RECIP);
    assign s5_minute_next = gwtc_pkg::MINUTE_W'(min_prod >> gwtc_pkg::MIN_SHIFT);

    // Guess the month from day of year, then correct by one
    assign doy_x4 = gwtc_pkg::LEFT_W'(s5_doy_reg) << 2;

    always_comb
    begin
        guess = gwtc_pkg::MONTH_W'(1);
        for (int k = 1; k < gwtc_pkg::MONTHS; k++)
        begin
            if (doy_x4 >= gwtc_pkg::LEFT_W'(125 * k))
                guess = guess + 1'b1;
        end
        guess_cum = gwtc_pkg::cum_days(s5_leap_reg, guess);

        s6_data_next              = '0;
        s6_data_next.year         = s5_year_reg;
        s6_data_next.day_of_year  = s5_doy_reg;
        s6_data_next.hour         = s5_hour_reg;
        s6_data_next.minute       = s5_minute_reg;
        s6_data_next.second_ms    = gwtc_pkg::SECMS_W'(s5_ms_reg
            - gwtc_pkg::MSHOUR_W'(s5_minute_reg)
            * gwtc_pkg::MSHOUR_W'(gwtc_pkg::MS_PER_MINUTE));
        if ((s5_doy_reg > guess_cum) && (guess < gwtc_pkg::MONTH_W'(gwtc_pkg::MONTHS)))
            s6_data_next.month = guess + 1'b1;
        else
            s6_data_next.month = guess;
    end

    // Subtract days before the month
    always_comb
    begin
        s7_data_next = s6_data_reg;
        s7_data_next.day_of_month = gwtc_pkg::DOM_W'(s6_data_reg.day_of_year
            - gwtc_pkg::cum_days(s6_leap_reg, s6_data_reg.month - 1'b1));
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
            s7_valid_reg <= 1'b0;
        end
        else
        begin
            if (s5_ready)
                s5_valid_reg <= up_valid;
            if (s6_ready)
                s6_valid_reg <= s5_valid_reg;
            if (s7_ready)
                s7_valid_reg <= s6_valid_reg;
        end
    end

    // Load payload on transfer into each stage
    always_ff @(posedge clk)
    begin
        if (s5_ready && up_valid)
        begin
            s5_year_reg   <= s5_year_next;
            s5_doy_reg    <= s5_doy_next;
            s5_leap_reg   <= (extra == 2'd3);
            s5_hour_reg   <= up_data.hour;
            s5_ms_reg     <= up_data.ms_of_hour;
            s5_minute_reg <= s5_minute_next;
        end
        if (s6_ready && s5_valid_reg)
        begin
            s6_data_reg <= s6_data_next;
            s6_leap_reg <= s5_leap_reg;
        end
        if (s7_ready && s6_valid_reg)
            s7_data_reg <= s7_data_next;
    end

    assign dn_valid = s7_valid_reg;
    assign dn_data  = s7_data_reg;

    a_month_range: assert property (@(posedge clk) disable iff (!rst_n)
        dn_valid |-> (dn_data.month >= gwtc_pkg::MONTH_W'(1))
            && (dn_data.month <= gwtc_pkg::MONTH_W'(gwtc_pkg::MONTHS)))
        else $error("month out of range");

    a_dom_range: assert property (@(posedge clk) disable iff (!rst_n)
        dn_valid |-> (dn_data.day_of_month >= gwtc_pkg::DOM_W'(1))
            && (dn_data.day_of_month <= gwtc_pkg::DOM_W'(31)))
        else $error("day of month out of range");

endmodule
